### src/jsld_pkg.sv
// ---------------------------------------------------------------------------
// jsld_pkg: shared types and constants for the JSON string list decoder
// Result kinds, parser phases, the result entry and the token bytes.
// ---------------------------------------------------------------------------
package jsld_pkg;

	// Kind of one result beat
	typedef enum logic [1:0] {
		KIND_BYTE = 2'd0,
		KIND_EOS  = 2'd1,
		KIND_DONE = 2'd2,
		KIND_ERR  = 2'd3
	} kind_t;

	// Parser phase
	typedef enum logic [2:0] {
		PH_OPEN         = 3'd0,
		PH_AFTER_OPEN   = 3'd1,
		PH_STRING       = 3'd2,
		PH_AFTER_STRING = 3'd3,
		PH_AFTER_COMMA  = 3'd4,
		PH_ERROR        = 3'd5
	} phase_t;

	// One queued result
	typedef struct packed {
		kind_t      kind;
		logic [7:0] data;
		logic       last;
	} result_t;

	localparam logic [7:0] CH_LBRACKET  = 8'h5B;
	localparam logic [7:0] CH_RBRACKET  = 8'h5D;
	localparam logic [7:0] CH_COMMA     = 8'h2C;
	localparam logic [7:0] CH_SPACE     = 8'h20;
	localparam logic [7:0] CH_BACKSLASH = 8'h5C;
	localparam logic [7:0] CH_QUOTE     = 8'h22;

	localparam logic [7:0] CH_LOWER_B = 8'h62;
	localparam logic [7:0] CH_LOWER_F = 8'h66;
	localparam logic [7:0] CH_LOWER_N = 8'h6E;
	localparam logic [7:0] CH_LOWER_R = 8'h72;
	localparam logic [7:0] CH_LOWER_T = 8'h74;

	localparam logic [7:0] CH_BS = 8'h08;
	localparam logic [7:0] CH_FF = 8'h0C;
	localparam logic [7:0] CH_LF = 8'h0A;
	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_HT = 8'h09;

endpackage

### src/json_string_list_decoder.sv
// ---------------------------------------------------------------------------
// json_string_list_decoder: byte-serial parser for a JSON array of strings
// Takes the text one byte per beat and emits unescaped string content,
// end-of-string marks, a list-complete mark and a one-shot error.
// ---------------------------------------------------------------------------
// Usage: feed the text on the s_axis side, one byte per beat, with tlast on
// the final byte. Each input beat is decoded in the cycle it is accepted: the
// parser phase and escape flag update at once and the zero, one or two result
// beats it causes are written into a four-entry result queue, which drains on
// the m_axis side one beat per cycle while m_axis_tready is high (kind on tuser,
// content byte on tdata, tlast on the last result of an input beat). The input
// side is ready while the queue holds at most two entries, so an input beat that
// yields at most one result goes through at one beat per cycle while m_axis is
// not stalled; one that yields two (an unknown escape) needs two output beats.
// Results are registered in the queue. Malformed text gives one error beat;
// later bytes are dropped until tlast, after which the parser expects a new '['.
// ---------------------------------------------------------------------------
module json_string_list_decoder
	import jsld_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,

	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,  // [7:0] in_byte
	input  logic       s_axis_tlast,  // in_end

	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,  // [7:0] out_byte
	output logic [1:0] m_axis_tuser,  // [1:0] kind
	output logic       m_axis_tlast   // out_last
);

	// parser state
	phase_t phase_q;
	logic   esc_q;

	// result queue
	result_t    queue_q [4];
	logic [1:0] wr_ptr_q;
	logic [1:0] rd_ptr_q;
	logic [2:0] count_q;

	// decode outputs
	phase_t     phase_d;
	logic       esc_d;
	logic [1:0] n_res;
	kind_t      kind0, kind1;
	logic [7:0] data0, data1;

	logic in_beat;
	logic out_beat;
	logic [7:0] b;
	logic       fin;

	assign b        = s_axis_tdata;
	assign fin      = s_axis_tlast;
	assign in_beat  = s_axis_tvalid && s_axis_tready;
	assign out_beat = m_axis_tvalid && m_axis_tready;

	// room for the worst case of two results
	assign s_axis_tready = (count_q <= 3'd2);

	// Byte decode: next phase and the results this byte causes
	always_comb begin
		phase_d = phase_q;
		esc_d   = esc_q;
		n_res   = 2'd0;
		kind0   = KIND_ERR;
		kind1   = KIND_BYTE;
		data0   = 8'h00;
		data1   = 8'h00;
		unique case (phase_q)
			PH_OPEN: begin
				if (b == CH_LBRACKET && !fin) begin
					phase_d = PH_AFTER_OPEN;
				end else begin
					n_res   = 2'd1;
					kind0   = KIND_ERR;
					phase_d = PH_ERROR;
				end
			end
			PH_AFTER_OPEN, PH_AFTER_STRING: begin
				if (fin) begin
					n_res = 2'd1;
					if (b == CH_RBRACKET) begin
						kind0 = KIND_DONE;
					end else begin
						kind0   = KIND_ERR;
						phase_d = PH_ERROR;
					end
				end else if (b == CH_SPACE) begin
					phase_d = phase_q;
				end else if (phase_q == PH_AFTER_OPEN && b == CH_QUOTE) begin
					phase_d = PH_STRING;
					esc_d   = 1'b0;
				end else if (phase_q == PH_AFTER_STRING && b == CH_COMMA) begin
					phase_d = PH_AFTER_COMMA;
				end else begin
					n_res   = 2'd1;
					kind0   = KIND_ERR;
					phase_d = PH_ERROR;
				end
			end
			PH_AFTER_COMMA: begin
				if (!fin && b == CH_SPACE) begin
					phase_d = phase_q;
				end else if (!fin && b == CH_QUOTE) begin
					phase_d = PH_STRING;
					esc_d   = 1'b0;
				end else begin
					n_res   = 2'd1;
					kind0   = KIND_ERR;
					phase_d = PH_ERROR;
				end
			end
			PH_STRING: begin
				if (fin) begin
					n_res   = 2'd1;
					kind0   = KIND_ERR;
					phase_d = PH_ERROR;
				end else if (esc_q) begin
					esc_d = 1'b0;
					n_res = 2'd1;
					kind0 = KIND_BYTE;
					case (b)
						CH_QUOTE:     data0 = CH_QUOTE;
						CH_BACKSLASH: data0 = CH_BACKSLASH;
						CH_LOWER_B:   data0 = CH_BS;
						CH_LOWER_F:   data0 = CH_FF;
						CH_LOWER_N:   data0 = CH_LF;
						CH_LOWER_R:   data0 = CH_CR;
						CH_LOWER_T:   data0 = CH_HT;
						default: begin
							// unknown escape keeps the backslash
							n_res = 2'd2;
							data0 = CH_BACKSLASH;
							kind1 = KIND_BYTE;
							data1 = b;
						end
					endcase
				end else if (b == CH_BACKSLASH) begin
					esc_d = 1'b1;
				end else if (b == CH_QUOTE) begin
					n_res   = 2'd1;
					kind0   = KIND_EOS;
					phase_d = PH_AFTER_STRING;
				end else begin
					n_res = 2'd1;
					kind0 = KIND_BYTE;
					data0 = b;
				end
			end
			default: begin
				// error phase: drop bytes until the final one
				phase_d = phase_q;
			end
		endcase
		if (fin) begin
			phase_d = PH_OPEN;
			esc_d   = 1'b0;
		end
	end

	// parser state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_OPEN;
			esc_q   <= 1'b0;
		end else if (in_beat) begin
			phase_q <= phase_d;
			esc_q   <= esc_d;
		end
	end

	// queue storage
	always_ff @(posedge clk) begin
		if (in_beat && n_res != 2'd0) begin
			queue_q[wr_ptr_q] <= '{kind: kind0, data: data0, last: (n_res == 2'd1)};
		end
		if (in_beat && n_res == 2'd2) begin
			queue_q[wr_ptr_q + 2'd1] <= '{kind: kind1, data: data1, last: 1'b1};
		end
	end

	// queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (in_beat) begin
				wr_ptr_q <= wr_ptr_q + n_res;
			end
			if (out_beat) begin
				rd_ptr_q <= rd_ptr_q + 2'd1;
			end
			count_q <= count_q + (in_beat ? {1'b0, n_res} : 3'd0)
				- {2'b00, out_beat};
		end
	end

	assign m_axis_tvalid = (count_q != 3'd0);
	assign m_axis_tuser  = queue_q[rd_ptr_q].kind;
	assign m_axis_tdata  = queue_q[rd_ptr_q].data;
	assign m_axis_tlast  = queue_q[rd_ptr_q].last;

endmodule
